>>> sv/csst_pkg.sv
// Shared constants and types for the cron schedule slot tracker.
// No dependencies; every other file of the block imports this package.
package csst_pkg;

  localparam int unsigned ENTRIES  = 32;
  localparam int unsigned SLOTS    = 32;
  localparam int unsigned COMMANDS = 32;

  localparam int unsigned EIDX_W = $clog2(ENTRIES);
  localparam int unsigned SIDX_W = $clog2(SLOTS);
  localparam int unsigned CIDX_W = $clog2(COMMANDS);

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] OP_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] OP_LOAD_RUN   = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;
  localparam logic [1:0] OP_REPORT     = 2'd3;

  localparam logic [1:0] CFG_MONTH   = 2'd0;
  localparam logic [1:0] CFG_WEEKDAY = 2'd1;

  // One schedule entry as held in the schedule memory.
  typedef struct packed {
    logic signed [6:0] minute;
    logic signed [5:0] hour;
    logic signed [5:0] date;
    logic signed [4:0] month;
    logic signed [3:0] weekday;
    logic [4:0]        command;
  } sched_t;

  // One run slot: busy flag and the minute at which it frees.
  typedef struct packed {
    logic        busy;
    logic [16:0] end_min;
  } slot_t;

endpackage

>>> sv/cron_schedule_slot_tracker_top.sv
// Top level of the cron schedule slot tracker.
// Depends on csst_pkg, csst_slot_cell and csst_cmd_cell.
//
// Usage. A transaction is accepted when start_i is high and busy_o is low.
// Every accepted transaction gives exactly one result, shown for one cycle
// with done_o high; the receiver cannot stall, so results are never held.
// Configuration writes use cfg_valid_i/cfg_ready_o; cfg_ready_o is always
// high, and writes are expected only while the block is idle.
//
// Sequence. Entry and run time loads finish at once: the result appears in
// the cycle after acceptance. A report sweeps the command counters, one per
// cycle, then answers. A tick first rotates the slot ring once round,
// freeing slots that end now, then streams the schedule memory through a
// three-stage read, match and allocate pipeline, then closes the minute.
// A tick past the month's end answers at once with status 1. busy_o is high
// while an operation is in progress.
//
// Reset. All slots become free, all entries invalid, all counters zero, the
// month January and the first weekday Saturday. Run times are undefined
// until loaded.
module cron_schedule_slot_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [4:0]  index_i,
  input  logic signed [6:0] entry_minute_i,
  input  logic signed [5:0] entry_hour_i,
  input  logic signed [5:0] entry_date_i,
  input  logic signed [4:0] entry_month_i,
  input  logic signed [3:0] entry_weekday_i,
  input  logic [4:0]  entry_command_i,
  input  logic [15:0] run_time_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  output logic        done_o,
  output logic        status_o,
  output logic [5:0]  started_now_o,
  output logic [5:0]  running_now_o,
  output logic [5:0]  max_running_o,
  output logic [15:0] total_started_o,
  output logic [4:0]  most_run_command_o,
  output logic [15:0] most_run_count_o
);
  import csst_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FREE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;
  localparam logic [2:0] ST_REPORT = 3'd5;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  logic [3:0] month_q;
  logic [2:0] fweek_q;

  // Calendar counters, advanced at the end of every completed tick.
  logic [15:0] now_q;
  logic [5:0]  min_q;
  logic [4:0]  hour_q;
  logic [4:0]  day_q;
  logic [2:0]  woff_q;

  logic [5:0]  busy_cnt_q;
  logic [5:0]  peak_q;
  logic [15:0] total_q;
  logic [5:0]  started_q;
  logic [4:0]  best_cmd_q;
  logic [15:0] best_cnt_q;

  logic accept;
  logic month_over;
  logic [15:0] month_len;

  assign accept      = start_i & ~busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q <= '0;
      fweek_q <= 3'd6;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MONTH) begin
        month_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_WEEKDAY) begin
        fweek_q <= cfg_data_i[2:0];
      end
    end
  end

  always_comb begin
    unique case (month_q)
      4'd1:                      month_len = 16'd40320;
      4'd3, 4'd5, 4'd8, 4'd10:   month_len = 16'd43200;
      default:                   month_len = 16'd44640;
    endcase
  end
  assign month_over = (now_q >= month_len);

  // Schedule memory, run time memory and entry valid bits.
  sched_t sched_mem [ENTRIES];
  logic [15:0] run_mem [COMMANDS];
  logic [ENTRIES-1:0] ent_v_q;
  sched_t sched_rd_q;
  logic [15:0] run_rd_q;
  logic [CIDX_W-1:0] run_raddr;

  always_ff @(posedge clk_i) begin
    if (accept && operation_i == OP_LOAD_ENTRY) begin
      sched_mem[index_i[EIDX_W-1:0]] <= '{entry_minute_i, entry_hour_i, entry_date_i,
                                         entry_month_i, entry_weekday_i, entry_command_i};
    end
    sched_rd_q <= sched_mem[cnt_q[EIDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept && operation_i == OP_LOAD_RUN) begin
      run_mem[index_i[CIDX_W-1:0]] <= run_time_i;
    end
    run_rd_q <= run_mem[run_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= '0;
    end else if (accept && operation_i == OP_LOAD_ENTRY) begin
      ent_v_q[index_i[EIDX_W-1:0]] <= 1'b1;
    end
  end

  // Match stage: the entry read last cycle is compared with the calendar.
  logic s1_v_q, s1_ent_v_q, s2_v_q;
  logic [CIDX_W-1:0] s2_cmd_q;
  logic [3:0] wsum;
  logic [2:0] wday;
  logic [5:0] day1;
  logic match;

  assign wsum = {1'b0, fweek_q} + {1'b0, woff_q};
  assign wday = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
  assign day1 = {1'b0, day_q} + 6'd1;

  assign match = s1_v_q && s1_ent_v_q &&
                 ((sched_rd_q.minute  == -7'sd1) || (sched_rd_q.minute  == {1'b0, min_q}))  &&
                 ((sched_rd_q.hour    == -6'sd1) || (sched_rd_q.hour    == {1'b0, hour_q})) &&
                 ((sched_rd_q.date    == -6'sd1) || (sched_rd_q.date    == day1))           &&
                 ((sched_rd_q.month   == -5'sd1) || (sched_rd_q.month   == {1'b0, month_q}))&&
                 ((sched_rd_q.weekday == -4'sd1) || (sched_rd_q.weekday == {1'b0, wday}));
  assign run_raddr = sched_rd_q.command[CIDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_ent_v_q <= 1'b0;
      s2_v_q     <= 1'b0;
      s2_cmd_q   <= '0;
    end else begin
      s1_v_q     <= (state_q == ST_SCAN);
      s1_ent_v_q <= ent_v_q[cnt_q[EIDX_W-1:0]];
      s2_v_q     <= match;
      s2_cmd_q   <= run_raddr;
    end
  end

  // Slot ring. Cell 0 is the head during the freeing rotation; its slot
  // re-enters at the tail, cleared if it ends this minute.
  slot_t slots [SLOTS];
  logic [SLOTS:0] found;
  slot_t head_back;
  logic  rot, head_free, alloc_ok;
  logic [16:0] alloc_end;
  logic [SLOTS-1:0] busy_vec;

  assign rot       = (state_q == ST_FREE);
  assign head_free = slots[0].busy && (slots[0].end_min == {1'b0, now_q});
  assign alloc_end = {1'b0, now_q} + {1'b0, run_rd_q};
  assign found[0]  = 1'b0;
  assign alloc_ok  = s2_v_q & found[SLOTS];

  always_comb begin
    head_back = slots[0];
    if (head_free) begin
      head_back.busy = 1'b0;
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    slot_t nxt;
    if (g == SLOTS - 1) begin : g_tail
      assign nxt = head_back;
    end else begin : g_mid
      assign nxt = slots[g+1];
    end
    csst_slot_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rot_i       (rot),
      .rot_slot_i  (nxt),
      .alloc_i     (s2_v_q),
      .alloc_end_i (alloc_end),
      .found_i     (found[g]),
      .found_o     (found[g+1]),
      .slot_o      (slots[g])
    );
    assign busy_vec[g] = slots[g].busy;
  end

  // Command start counters.
  logic [15:0] cmd_cnt [COMMANDS];
  for (genvar c = 0; c < COMMANDS; c++) begin : g_cmd
    csst_cmd_cell u_cmd (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .inc_i   (alloc_ok && (s2_cmd_q == CIDX_W'(c))),
      .count_o (cmd_cnt[c])
    );
  end

  logic [15:0] rep_cnt;
  assign rep_cnt = cmd_cnt[cnt_q[CIDX_W-1:0]];

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && operation_i == OP_TICK && !month_over) begin
          state_d = ST_FREE;
        end else if (accept && operation_i == OP_REPORT) begin
          state_d = ST_REPORT;
        end
      end
      ST_FREE: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SLOTS - 1)) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(ENTRIES - 1)) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      ST_REPORT: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(COMMANDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Counters for busy slots, peak, totals, the report search and the calendar.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_cnt_q <= '0;
      peak_q     <= '0;
      total_q    <= '0;
      started_q  <= '0;
      best_cmd_q <= '0;
      best_cnt_q <= '0;
      now_q      <= '0;
      min_q      <= '0;
      hour_q     <= '0;
      day_q      <= '0;
      woff_q     <= '0;
    end else begin
      if (state_q == ST_IDLE) begin
        started_q  <= '0;
        best_cmd_q <= '0;
        best_cnt_q <= '0;
      end
      if (rot && head_free && busy_cnt_q != 6'd0) begin
        busy_cnt_q <= busy_cnt_q - 6'd1;
      end
      if (alloc_ok) begin
        busy_cnt_q <= busy_cnt_q + 6'd1;
        if (busy_cnt_q + 6'd1 > peak_q) begin
          peak_q <= busy_cnt_q + 6'd1;
        end
        if (total_q != COUNT_MAX) begin
          total_q <= total_q + 16'd1;
        end
        started_q <= started_q + 6'd1;
      end
      if (state_q == ST_REPORT && rep_cnt > best_cnt_q) begin
        best_cnt_q <= rep_cnt;
        best_cmd_q <= 5'(cnt_q);
      end
      if (state_q == ST_FIN) begin
        now_q  <= now_q + 16'd1;
        if (min_q == 6'd59) begin
          min_q <= '0;
          if (hour_q == 5'd23) begin
            hour_q <= '0;
            day_q  <= day_q + 5'd1;
            woff_q <= (woff_q == 3'd6) ? 3'd0 : woff_q + 3'd1;
          end else begin
            hour_q <= hour_q + 5'd1;
          end
        end else begin
          min_q <= min_q + 6'd1;
        end
      end
    end
  end

  // Result register: loads answer at once, a tick past month end too.
  logic res_now;
  assign res_now = (accept && (operation_i == OP_LOAD_ENTRY ||
                               operation_i == OP_LOAD_RUN ||
                               (operation_i == OP_TICK && month_over))) ||
                   (state_q == ST_FIN) ||
                   (state_q == ST_REPORT && cnt_q == 6'(COMMANDS - 1));

  logic        fin_rep;
  logic        rep_take;
  assign fin_rep  = (state_q == ST_REPORT);
  assign rep_take = fin_rep && (rep_cnt > best_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= res_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_now) begin
      status_o           <= (state_q == ST_IDLE) && (operation_i == OP_TICK);
      started_now_o      <= (state_q == ST_FIN) ? started_q : 6'd0;
      running_now_o      <= busy_cnt_q;
      max_running_o      <= peak_q;
      total_started_o    <= total_q;
      most_run_command_o <= fin_rep ? (rep_take ? 5'(cnt_q) : best_cmd_q) : 5'd0;
      most_run_count_o   <= fin_rep ? (rep_take ? rep_cnt : best_cnt_q) : 16'd0;
    end
  end

`ifndef SYNTHESIS
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(busy_vec) == 32'(busy_cnt_q)))
    else $error("busy count disagrees with the slot ring");
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= busy_cnt_q)
    else $error("peak below current busy count");
  a_alloc_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("allocation outside the scan window");
`endif

endmodule

>>> sv/csst_slot_cell.sv
// One run slot of the slot ring for the cron schedule slot tracker.
// Depends on csst_pkg for the slot type.
module csst_slot_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rot_i,
  input  csst_pkg::slot_t rot_slot_i,
  input  logic            alloc_i,
  input  logic [16:0]     alloc_end_i,
  input  logic            found_i,
  output logic            found_o,
  output csst_pkg::slot_t slot_o
);
  import csst_pkg::*;

  slot_t slot_q, slot_d;
  logic  take;

  // The first free cell along the chain claims the allocation.
  assign take    = alloc_i & ~found_i & ~slot_q.busy;
  assign found_o = found_i | ~slot_q.busy;
  assign slot_o  = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (rot_i) begin
      slot_d = rot_slot_i;
    end else if (take) begin
      slot_d.busy    = 1'b1;
      slot_d.end_min = alloc_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

>>> sv/csst_cmd_cell.sv
// Saturating start counter for one command of the cron schedule slot tracker.
// Depends on csst_pkg for the counter ceiling.
module csst_cmd_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        inc_i,
  output logic [15:0] count_o
);
  import csst_pkg::*;

  logic [15:0] count_q, count_d;

  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (inc_i && (count_q != COUNT_MAX)) begin
      count_d = count_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule
